/* rtl/ate_pkg.sv */
// Shared types, sizes and helpers for the array table engine.
package ate_pkg;

  localparam int DEPTH  = 128;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int SUM_W  = 39;
  localparam int POS_W  = 7;
  localparam int NUM_W  = 8;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_REPLACE = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_SEARCH  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  function automatic logic [SUM_W-1:0] widen(input logic [DATA_W-1:0] v);
    return {{(SUM_W - DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage

/* rtl/ate_if.sv */
// Request and response channel interfaces for the array table engine.
interface ate_req_if;
  logic                              valid;
  logic                              ready;
  ate_pkg::cmd_t                     command;
  logic signed [ate_pkg::DATA_W-1:0] key_value;
  logic signed [ate_pkg::DATA_W-1:0] replacement_value;

  modport source (output valid, command, key_value, replacement_value, input ready);
  modport sink   (input valid, command, key_value, replacement_value, output ready);
endinterface

interface ate_rsp_if;
  logic                             valid;
  logic                             ready;
  ate_pkg::status_t                 status;
  logic [ate_pkg::POS_W-1:0]        position;
  logic [ate_pkg::NUM_W-1:0]        match_count;
  logic [ate_pkg::NUM_W-1:0]        entry_count;
  logic signed [ate_pkg::SUM_W-1:0] total_sum;

  modport source (output valid, status, position, match_count, entry_count, total_sum,
                  input ready);
  modport sink   (input valid, status, position, match_count, entry_count, total_sum,
                  output ready);
endinterface

/* rtl/array_table_engine.sv */
// Packed signed-entry store with append, replace-all, delete-first and search commands.
// One request is worked at a time and every request yields one response beat. Append
// goes straight to the finish state, which registers its response once the output
// register is free. Replace and delete walk all valid entries and search walks up to its
// first match, one entry per cycle through the single read port of the entry memory
// (registered read data), then finish the same way; delete shifts later entries down
// during the same walk. The input reopens the cycle after a response is registered.
// A finished response waits in its output register while the next request is accepted;
// the response after that holds, and blocks the input, until the waiting beat drains.
// The entry memory needs no clearing after reset: only entries below the entry count
// are ever read.
module array_table_engine (
  input  logic          clk,
  input  logic          rst,
  ate_req_if.sink       req,
  ate_rsp_if.source     rsp
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                          state;
  ate_pkg::cmd_t                   cmd;
  logic [ate_pkg::DATA_W-1:0]      key;
  logic [ate_pkg::DATA_W-1:0]      rep;
  logic [ate_pkg::CNT_W-1:0]       count;
  logic [ate_pkg::SUM_W-1:0]       total;
  logic [ate_pkg::CNT_W-1:0]       issue_idx;
  logic                            pipe_valid;
  logic [ate_pkg::ADDR_W-1:0]      pipe_idx;
  logic                            found;
  logic [ate_pkg::ADDR_W-1:0]      pos;
  logic [ate_pkg::CNT_W-1:0]       match_num;

  logic                            res_valid;
  ate_pkg::status_t                res_status;
  logic [ate_pkg::POS_W-1:0]       res_position;
  logic [ate_pkg::NUM_W-1:0]       res_matches;
  logic [ate_pkg::NUM_W-1:0]       res_count;
  logic [ate_pkg::SUM_W-1:0]       res_total;

  logic [ate_pkg::DATA_W-1:0]      mem [ate_pkg::DEPTH];
  logic [ate_pkg::DATA_W-1:0]      rdata;
  logic                            rd_en;
  logic [ate_pkg::ADDR_W-1:0]      rd_addr;
  logic                            wr_en;
  logic [ate_pkg::ADDR_W-1:0]      wr_addr;
  logic [ate_pkg::DATA_W-1:0]      wr_data;

  logic                            accept;
  logic                            hit;
  logic                            stop_search;
  logic                            scan_done;
  logic                            room;

  assign req.ready       = (state == S_IDLE);
  assign accept          = req.valid && req.ready;
  assign room            = (count < ate_pkg::DEPTH_CNT);
  assign hit             = pipe_valid && (rdata == key);
  assign stop_search     = (cmd == ate_pkg::CMD_SEARCH) && hit;
  assign scan_done       = (state == S_SCAN) &&
                           (stop_search || (!pipe_valid && (issue_idx >= count)));

  assign rsp.valid       = res_valid;
  assign rsp.status      = res_status;
  assign rsp.position    = res_position;
  assign rsp.match_count = res_matches;
  assign rsp.entry_count = res_count;
  assign rsp.total_sum   = res_total;

  always_comb begin
    rd_en   = (state == S_SCAN) && (issue_idx < count) && !stop_search;
    rd_addr = issue_idx[ate_pkg::ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = pipe_idx;
    wr_data = rep;
    if (accept && (req.command == ate_pkg::CMD_APPEND) && room) begin
      wr_en   = 1'b1;
      wr_addr = count[ate_pkg::ADDR_W-1:0];
      wr_data = req.key_value;
    end else if ((state == S_SCAN) && (cmd == ate_pkg::CMD_REPLACE) && hit) begin
      wr_en   = 1'b1;
      wr_addr = pipe_idx;
      wr_data = rep;
    end else if ((state == S_SCAN) && (cmd == ate_pkg::CMD_DELETE) && pipe_valid && found) begin
      wr_en   = 1'b1;
      wr_addr = pipe_idx - ate_pkg::ADDR_W'(1);
      wr_data = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    pipe_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      total      <= '0;
      pipe_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      pipe_valid <= rd_en;
      if (rsp.ready && (state != S_FINISH)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd       <= req.command;
            key       <= req.key_value;
            rep       <= req.replacement_value;
            found     <= 1'b0;
            match_num <= '0;
            pos       <= '0;
            issue_idx <= '0;
            if (req.command == ate_pkg::CMD_APPEND) begin
              if (room) begin
                count     <= count + ate_pkg::CNT_W'(1);
                total     <= total + ate_pkg::widen(req.key_value);
                pos       <= count[ate_pkg::ADDR_W-1:0];
                match_num <= ate_pkg::CNT_W'(1);
                found     <= 1'b1;
              end
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            issue_idx <= issue_idx + ate_pkg::CNT_W'(1);
          end
          if (hit && (!found || (cmd == ate_pkg::CMD_REPLACE))) begin
            if (!found) begin
              pos <= pipe_idx;
            end
            found <= 1'b1;
            if (cmd == ate_pkg::CMD_REPLACE) begin
              match_num <= match_num + ate_pkg::CNT_W'(1);
              total     <= total + ate_pkg::widen(rep) - ate_pkg::widen(key);
            end
          end
          if (scan_done) begin
            if ((cmd == ate_pkg::CMD_DELETE) && found) begin
              count <= count - ate_pkg::CNT_W'(1);
              total <= total - ate_pkg::widen(key);
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!res_valid || rsp.ready) begin
            res_valid    <= 1'b1;
            res_status   <= found ? ate_pkg::ST_OK :
                            ((cmd == ate_pkg::CMD_APPEND) ? ate_pkg::ST_FULL :
                                                            ate_pkg::ST_NOT_FOUND);
            res_position <= ate_pkg::POS_W'(pos);
            res_matches  <= (cmd == ate_pkg::CMD_REPLACE) ? ate_pkg::NUM_W'(match_num) :
                                                            ate_pkg::NUM_W'(found);
            res_count    <= ate_pkg::NUM_W'(count);
            res_total    <= total;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ate_pkg::DEPTH_CNT)
    else $error("entry count above depth");

  a_scan_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (state == S_SCAN)) |-> (ate_pkg::CNT_W'(wr_addr) < count))
    else $error("scan write outside valid entries");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (rst)
    pipe_valid |-> (state == S_SCAN))
    else $error("read beat outstanding outside scan");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((count == $past(count)) ||
                     (count == $past(count) + ate_pkg::CNT_W'(1)) ||
                     (count == $past(count) - ate_pkg::CNT_W'(1))))
    else $error("entry count moved by more than one");

endmodule

/* sim/array_table_engine_tb.sv */
// Self-checking testbench for the array table engine: random and directed commands, scoreboard.
`timescale 1ns / 100ps

module array_table_engine_tb;

  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 400;
  localparam logic signed [ate_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [ate_pkg::DATA_W-1:0] VAL_MIN = 32'sh80000000;

  typedef struct {
    ate_pkg::cmd_t                     command;
    logic signed [ate_pkg::DATA_W-1:0] key;
    logic signed [ate_pkg::DATA_W-1:0] rep;
    int unsigned                       gap;
  } table_cmd_t;

  typedef struct {
    ate_pkg::status_t                 status;
    logic [ate_pkg::POS_W-1:0]        position;
    logic [ate_pkg::NUM_W-1:0]        match_num;
    logic [ate_pkg::NUM_W-1:0]        count;
    logic signed [ate_pkg::SUM_W-1:0] total;
  } table_result_t;

  logic clk;
  logic rst;

  ate_req_if req_ch ();
  ate_rsp_if rsp_ch ();

  array_table_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  table_cmd_t                        cmd_queue[$];
  table_result_t                     pending_results[$];
  logic signed [ate_pkg::DATA_W-1:0] shadow_store[ate_pkg::DEPTH];
  int                                live_count;
  logic signed [ate_pkg::SUM_W-1:0]  live_total;

  table_cmd_t next_cmd;
  bit         req_beat;
  bit         rsp_beat;
  int         send_wait;
  int         recv_wait;
  bit         send_quiet;
  bit         recv_quiet;
  int         items_made;
  int         results_seen;
  int         errors;
  int         cmd_seen[4];
  int         n_missing;
  int         n_full;
  int         peak_count;

  logic signed [ate_pkg::DATA_W-1:0] value_pool[8] = '{
    32'sd0, 32'sd1, -32'sd1, VAL_MAX, VAL_MIN, 32'sd5, -32'sd5, 32'sd1000
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [ate_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return value_pool[$urandom_range(0, 7)];
  endfunction

  function automatic ate_pkg::cmd_t draw_cmd(int w_app, int w_rep, int w_del);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_app) return ate_pkg::CMD_APPEND;
    if (r < w_app + w_rep) return ate_pkg::CMD_REPLACE;
    if (r < w_app + w_rep + w_del) return ate_pkg::CMD_DELETE;
    return ate_pkg::CMD_SEARCH;
  endfunction

  function automatic void push_cmd(ate_pkg::cmd_t c, logic signed [ate_pkg::DATA_W-1:0] k,
                                   logic signed [ate_pkg::DATA_W-1:0] r);
    table_cmd_t t;
    if (items_made % 30 == 0) send_quiet = ($urandom_range(0, 2) == 0);
    t.command = c;
    t.key     = k;
    t.rep     = r;
    t.gap     = send_quiet ? 0 : $urandom_range(0, 19);
    cmd_queue.push_back(t);
    items_made++;
  endfunction

  function automatic void add_mix(int n, int w_app, int w_rep, int w_del);
    for (int i = 0; i < n; i++) push_cmd(draw_cmd(w_app, w_rep, w_del), pick_value(), pick_value());
  endfunction

  function automatic table_result_t table_apply(table_cmd_t c);
    table_result_t r;
    int hit;
    int n;
    r.status    = ate_pkg::ST_OK;
    r.position  = '0;
    r.match_num = '0;
    hit = -1;
    n = 0;
    case (c.command)
      ate_pkg::CMD_APPEND: begin
        if (live_count < ate_pkg::DEPTH) begin
          shadow_store[live_count] = c.key;
          r.position = ate_pkg::POS_W'(live_count);
          live_count++;
          live_total = live_total + c.key;
          r.match_num = 1;
        end else begin
          r.status = ate_pkg::ST_FULL;
        end
      end
      ate_pkg::CMD_REPLACE: begin
        for (int i = 0; i < live_count; i++) begin
          if (shadow_store[i] == c.key) begin
            if (hit < 0) hit = i;
            shadow_store[i] = c.rep;
            n++;
            live_total = live_total + c.rep - c.key;
          end
        end
        if (hit < 0) r.status = ate_pkg::ST_NOT_FOUND;
        else r.position = ate_pkg::POS_W'(hit);
        r.match_num = ate_pkg::NUM_W'(n);
      end
      default: begin
        for (int i = 0; i < live_count && hit < 0; i++) begin
          if (shadow_store[i] == c.key) hit = i;
        end
        if (hit < 0) begin
          r.status = ate_pkg::ST_NOT_FOUND;
        end else begin
          r.position  = ate_pkg::POS_W'(hit);
          r.match_num = 1;
          if (c.command == ate_pkg::CMD_DELETE) begin
            for (int i = hit; i + 1 < live_count; i++) shadow_store[i] = shadow_store[i + 1];
            live_count--;
            live_total = live_total - c.key;
          end
        end
      end
    endcase
    r.count = ate_pkg::NUM_W'(live_count);
    r.total = live_total;
    return r;
  endfunction

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    table_cmd_t    taken;
    table_result_t want;
    req_beat = !rst && req_ch.valid && req_ch.ready;
    rsp_beat = !rst && rsp_ch.valid && rsp_ch.ready;
    if (req_beat) begin
      taken.command = req_ch.command;
      taken.key     = req_ch.key_value;
      taken.rep     = req_ch.replacement_value;
      taken.gap     = 0;
      cmd_seen[taken.command]++;
      pending_results.push_back(table_apply(taken));
      if (live_count > peak_count) peak_count = live_count;
    end
    if (rsp_beat) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected response beat, expected none, got status %0d",
                 $time, rsp_ch.status);
      end else begin
        want = pending_results.pop_front();
        if (want.status == ate_pkg::ST_NOT_FOUND) n_missing++;
        if (want.status == ate_pkg::ST_FULL) n_full++;
        check_field("status", want.status, rsp_ch.status);
        check_field("position", want.position, rsp_ch.position);
        check_field("match_count", want.match_num, rsp_ch.match_count);
        check_field("entry_count", want.count, rsp_ch.entry_count);
        check_field("total_sum", want.total, rsp_ch.total_sum);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && (!req_ch.valid || req_beat)) begin
      if (send_wait > 0) begin
        req_ch.valid <= 1'b0;
        send_wait--;
      end else if (cmd_queue.size() > 0) begin
        next_cmd = cmd_queue.pop_front();
        req_ch.valid             <= 1'b1;
        req_ch.command           <= next_cmd.command;
        req_ch.key_value         <= next_cmd.key;
        req_ch.replacement_value <= next_cmd.rep;
        if (cmd_queue.size() > 0) send_wait = cmd_queue[0].gap;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // hold off once for a long stretch so the engine backs up into its input
  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_beat) begin
        if (results_seen == HOLD_AT) recv_wait = HOLD_CYCLES;
        else recv_wait = recv_quiet ? 0 : $urandom_range(0, 19);
        if (results_seen % 32 == 0) recv_quiet = ($urandom_range(0, 2) == 0);
      end
      if (recv_wait > 0) begin
        rsp_ch.ready <= 1'b0;
        recv_wait--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = ate_pkg::CMD_APPEND;
    req_ch.key_value = '0;
    req_ch.replacement_value = '0;
    rsp_ch.ready = 1'b0;
    live_count = 0;
    live_total = '0;
    send_wait = 0;
    recv_wait = 0;
    errors = 0;
    results_seen = 0;
    items_made = 0;
    peak_count = 0;
    n_missing = 0;
    n_full = 0;
    cmd_seen = '{default: 0};

    push_cmd(ate_pkg::CMD_SEARCH, 32'sd5, 32'sd0);
    push_cmd(ate_pkg::CMD_REPLACE, 32'sd5, 32'sd6);
    push_cmd(ate_pkg::CMD_DELETE, 32'sd5, VAL_MAX);
    push_cmd(ate_pkg::CMD_APPEND, VAL_MIN, VAL_MIN);
    push_cmd(ate_pkg::CMD_APPEND, VAL_MAX, 32'sd0);
    push_cmd(ate_pkg::CMD_APPEND, 32'sd0, -32'sd1);
    push_cmd(ate_pkg::CMD_APPEND, -32'sd1, 32'sd0);
    push_cmd(ate_pkg::CMD_APPEND, 32'sd7, 32'sd0);
    push_cmd(ate_pkg::CMD_APPEND, 32'sh55555555, 32'shaaaaaaaa);
    push_cmd(ate_pkg::CMD_APPEND, 32'sd7, 32'sd0);
    push_cmd(ate_pkg::CMD_APPEND, 32'shaaaaaaaa, 32'sh55555555);
    push_cmd(ate_pkg::CMD_APPEND, 32'sd7, 32'sd0);
    push_cmd(ate_pkg::CMD_SEARCH, 32'sd7, 32'sd0);
    push_cmd(ate_pkg::CMD_SEARCH, VAL_MIN, 32'sd0);
    push_cmd(ate_pkg::CMD_REPLACE, 32'sd7, VAL_MIN);
    push_cmd(ate_pkg::CMD_REPLACE, VAL_MIN, VAL_MAX);
    push_cmd(ate_pkg::CMD_DELETE, VAL_MAX, 32'sd0);
    push_cmd(ate_pkg::CMD_DELETE, 32'shaaaaaaaa, 32'sd0);
    push_cmd(ate_pkg::CMD_DELETE, 32'sd12345, 32'sd0);
    push_cmd(ate_pkg::CMD_SEARCH, -32'sd1, 32'sd0);
    push_cmd(ate_pkg::CMD_REPLACE, 32'sd0, -32'sd1);
    push_cmd(ate_pkg::CMD_SEARCH, 32'sd12345, 32'sd0);

    add_mix(40, 25, 25, 25);
    for (int i = 0; i < 140; i++)
      push_cmd(ate_pkg::CMD_APPEND, $urandom_range(0, 1) ? VAL_MAX : pick_value(), pick_value());
    push_cmd(ate_pkg::CMD_SEARCH, VAL_MAX, 32'sd0);
    push_cmd(ate_pkg::CMD_REPLACE, VAL_MAX, VAL_MIN);
    push_cmd(ate_pkg::CMD_DELETE, VAL_MIN, 32'sd0);
    push_cmd(ate_pkg::CMD_APPEND, VAL_MIN, 32'sd0);
    push_cmd(ate_pkg::CMD_APPEND, VAL_MAX, 32'sd0);
    add_mix(60, 30, 20, 25);
    add_mix(60, 10, 10, 70);
    add_mix(70, 25, 25, 25);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (cmd_queue.size() > 0 || req_ch.valid) @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (ate_pkg::DEPTH + 8) @(posedge clk);

    $display("Covered %0d appends, %0d replaces, %0d deletes, %0d searches.",
             cmd_seen[ate_pkg::CMD_APPEND], cmd_seen[ate_pkg::CMD_REPLACE],
             cmd_seen[ate_pkg::CMD_DELETE], cmd_seen[ate_pkg::CMD_SEARCH]);
    $display("Saw %0d misses, %0d full-store appends, peak of %0d entries.",
             n_missing, n_full, peak_count);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
